// ----- design/fdsu_pkg.sv -----
// Shared definitions for the Forth data stack unit.
// Holds the command codes, error codes, fixed port widths and the control struct.
// No dependencies.
package fdsu_pkg;

   // Fixed widths of the request and response fields.
   localparam int CMD_W       = 4;
   localparam int PORT_VAL_W  = 64;
   localparam int ERR_W       = 2;
   localparam int DEPTH_OUT_W = 7;

   // Command codes carried by a request.
   localparam logic [CMD_W-1:0] CMD_PUSH      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_POP       = 4'd1;
   localparam logic [CMD_W-1:0] CMD_DUP       = 4'd2;
   localparam logic [CMD_W-1:0] CMD_SWAP      = 4'd3;
   localparam logic [CMD_W-1:0] CMD_ROT       = 4'd4;
   localparam logic [CMD_W-1:0] CMD_OVER      = 4'd5;
   localparam logic [CMD_W-1:0] CMD_DROP      = 4'd6;
   localparam logic [CMD_W-1:0] CMD_DROP2     = 4'd7;
   localparam logic [CMD_W-1:0] CMD_MINUS_ROT = 4'd8;

   // Error codes returned with every response.
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
   localparam logic [ERR_W-1:0] ERR_UNDER = 2'd3;

   // Control outputs of the execute logic.
   typedef struct packed {
      logic [ERR_W-1:0] error_code;
      logic             spill_we;
   } fdsu_ctl_type;

endpackage

// ----- design/fdsu_spill_ram.sv -----
// Spill memory of the Forth data stack unit: one write port, two registered read ports.
// A read of the address written in the same cycle returns the new data.
// Depends on nothing.
module fdsu_spill_ram #(
   parameter int VALUE_WIDTH = 64,
   parameter int STACK_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
   input  logic [VALUE_WIDTH-1:0]         wdata,
   input  logic [$clog2(STACK_DEPTH)-1:0] raddr_a,
   input  logic [$clog2(STACK_DEPTH)-1:0] raddr_b,
   output logic [VALUE_WIDTH-1:0]         rdata_a,
   output logic [VALUE_WIDTH-1:0]         rdata_b
);

   logic [VALUE_WIDTH-1:0] store_mem [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_a_ff;
   logic [VALUE_WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (we && (waddr == raddr_a)) begin
         rd_a_ff <= wdata;
      end else begin
         rd_a_ff <= store_mem[raddr_a];
      end
      if (we && (waddr == raddr_b)) begin
         rd_b_ff <= wdata;
      end else begin
         rd_b_ff <= store_mem[raddr_b];
      end
   end

   assign rdata_a = rd_a_ff;
   assign rdata_b = rd_b_ff;

endmodule

// ----- design/fdsu_exec.sv -----
// Execute logic of the Forth data stack unit: next stack state and response for one command.
// Works on the three cached top entries and the two prefetched entries below them.
// Depends on fdsu_pkg.
module fdsu_exec #(
   parameter int VALUE_WIDTH = 64,
   parameter int STACK_DEPTH = 64
) (
   input  logic                               go,
   input  logic [fdsu_pkg::CMD_W-1:0]         command,
   input  logic [VALUE_WIDTH-1:0]             push_value,
   input  logic [$clog2(STACK_DEPTH+1)-1:0]   count,
   input  logic [VALUE_WIDTH-1:0]             t0,
   input  logic [VALUE_WIDTH-1:0]             t1,
   input  logic [VALUE_WIDTH-1:0]             t2,
   input  logic [VALUE_WIDTH-1:0]             b3,
   input  logic [VALUE_WIDTH-1:0]             b4,
   output logic [$clog2(STACK_DEPTH+1)-1:0]   count_n,
   output logic [VALUE_WIDTH-1:0]             t0_n,
   output logic [VALUE_WIDTH-1:0]             t1_n,
   output logic [VALUE_WIDTH-1:0]             t2_n,
   output logic [VALUE_WIDTH-1:0]             popped,
   output fdsu_pkg::fdsu_ctl_type             ctl,
   output logic [$clog2(STACK_DEPTH)-1:0]     spill_addr,
   output logic [$clog2(STACK_DEPTH)-1:0]     rd3_addr,
   output logic [$clog2(STACK_DEPTH)-1:0]     rd4_addr
);
   import fdsu_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int EW = CW + 2;

   logic [EW-1:0]          cx;
   logic [EW-1:0]          nx;
   logic                   push_en;
   logic [VALUE_WIDTH-1:0] push_data;
   logic                   is_full;

   assign cx      = EW'(count);
   assign nx      = EW'(count_n);
   assign is_full = (cx >= EW'(STACK_DEPTH));

   always_comb begin
      count_n        = count;
      t0_n           = t0;
      t1_n           = t1;
      t2_n           = t2;
      popped         = '0;
      ctl.error_code = ERR_OK;
      ctl.spill_we   = 1'b0;
      push_en        = 1'b0;
      push_data      = t0;
      case (command)
         CMD_PUSH: begin
            if (is_full) begin
               ctl.error_code = ERR_FULL;
            end else begin
               push_en   = 1'b1;
               push_data = push_value;
            end
         end
         CMD_POP: begin
            if (cx == '0) begin
               ctl.error_code = ERR_EMPTY;
            end else begin
               popped  = t0;
               t0_n    = t1;
               t1_n    = t2;
               t2_n    = b3;
               count_n = count - CW'(1);
            end
         end
         CMD_DUP: begin
            if (cx == '0) begin
               ctl.error_code = ERR_EMPTY;
            end else if (is_full) begin
               ctl.error_code = ERR_FULL;
            end else begin
               push_en   = 1'b1;
               push_data = t0;
            end
         end
         CMD_SWAP: begin
            if (cx < EW'(2)) begin
               ctl.error_code = ERR_UNDER;
            end else begin
               t0_n = t1;
               t1_n = t0;
            end
         end
         CMD_ROT: begin
            // ( a b c -- b c a ) with c on top.
            if (cx < EW'(3)) begin
               ctl.error_code = ERR_UNDER;
            end else begin
               t0_n = t2;
               t1_n = t0;
               t2_n = t1;
            end
         end
         CMD_OVER: begin
            if (cx < EW'(2)) begin
               ctl.error_code = ERR_UNDER;
            end else if (is_full) begin
               ctl.error_code = ERR_FULL;
            end else begin
               push_en   = 1'b1;
               push_data = t1;
            end
         end
         CMD_DROP: begin
            if (cx == '0) begin
               ctl.error_code = ERR_EMPTY;
            end else begin
               t0_n    = t1;
               t1_n    = t2;
               t2_n    = b3;
               count_n = count - CW'(1);
            end
         end
         CMD_DROP2: begin
            if (cx < EW'(2)) begin
               ctl.error_code = ERR_UNDER;
            end else begin
               t0_n    = t2;
               t1_n    = b3;
               t2_n    = b4;
               count_n = count - CW'(2);
            end
         end
         CMD_MINUS_ROT: begin
            // ( a b c -- c a b ) with c on top.
            if (cx < EW'(3)) begin
               ctl.error_code = ERR_UNDER;
            end else begin
               t0_n = t1;
               t1_n = t2;
               t2_n = t0;
            end
         end
         default: begin
         end
      endcase

      // Every push shifts the cache down; at depth three or more the third entry spills.
      if (push_en) begin
         t0_n         = push_data;
         t1_n         = t0;
         t2_n         = t1;
         count_n      = count + CW'(1);
         ctl.spill_we = (cx >= EW'(3));
      end

      if (!go) begin
         count_n      = count;
         t0_n         = t0;
         t1_n         = t1;
         t2_n         = t2;
         ctl.spill_we = 1'b0;
      end
   end

   // Prefetch addresses follow the depth that the stack will have next cycle.
   always_comb begin
      spill_addr = AW'(cx - EW'(3));
      rd3_addr   = (nx >= EW'(4)) ? AW'(nx - EW'(4)) : '0;
      rd4_addr   = (nx >= EW'(5)) ? AW'(nx - EW'(5)) : '0;
   end

endmodule

// ----- design/forth_data_stack_unit_top.sv -----
// Top level of the Forth data stack unit.
// Instantiates the execute logic and the spill memory. Depends on fdsu_pkg,
// fdsu_exec and fdsu_spill_ram.

// The unit accepts one stack request per clock cycle while the response side
// is not stalled and returns one response per request, in order: the request
// is first captured in a request register and is then executed against the
// stack state, which loads the response register. The throughput of one
// request per cycle is set by the execute stage, which holds the three top
// stack entries in registers and keeps two more entries below them
// prefetched from a spill memory with one write port and two registered read
// ports, so every command finishes in a single pass.
// The request side's ready follows the response side's ready in the same
// cycle. The spill memory is not cleared after reset and needs no clearing
// pass; the depth checks make sure that only written entries are ever used.
// Values wider than VALUE_WIDTH are truncated on push and zero-extended on pop.
module forth_data_stack_unit_top #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_WIDTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fdsu_pkg::CMD_W-1:0]          req_command,
   input  logic [fdsu_pkg::PORT_VAL_W-1:0]     req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fdsu_pkg::PORT_VAL_W-1:0]     rsp_popped_value,
   output logic [fdsu_pkg::ERR_W-1:0]          rsp_error_code,
   output logic [fdsu_pkg::DEPTH_OUT_W-1:0]    rsp_depth_after
);
   import fdsu_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   // Request register.
   logic                   a_valid_ff;
   logic                   a_valid_in;
   logic [CMD_W-1:0]       a_cmd_ff;
   logic [VALUE_WIDTH-1:0] a_val_ff;

   // Stack state: depth and the three cached top entries.
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [VALUE_WIDTH-1:0] t0_ff;
   logic [VALUE_WIDTH-1:0] t1_ff;
   logic [VALUE_WIDTH-1:0] t2_ff;
   logic [VALUE_WIDTH-1:0] t0_in;
   logic [VALUE_WIDTH-1:0] t1_in;
   logic [VALUE_WIDTH-1:0] t2_in;

   // Response register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_popped_ff;
   logic [ERR_W-1:0]       rsp_err_ff;
   logic [DEPTH_OUT_W-1:0] rsp_depth_ff;

   logic                   a_adv;
   logic                   fire;
   logic [VALUE_WIDTH-1:0] b3;
   logic [VALUE_WIDTH-1:0] b4;
   logic [VALUE_WIDTH-1:0] popped;
   fdsu_ctl_type           ctl;
   logic [AW-1:0]          spill_addr;
   logic [AW-1:0]          rd3_addr;
   logic [AW-1:0]          rd4_addr;

   // The execute stage moves on whenever the response register is free or
   // is being emptied in this cycle.
   assign a_adv      = !rsp_valid_ff || rsp_ready;
   assign fire       = a_valid_ff && a_adv;
   assign req_ready  = !a_valid_ff || a_adv;
   assign a_valid_in = req_ready ? req_valid : a_valid_ff;

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   fdsu_exec #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_exec (
      .go         (fire),
      .command    (a_cmd_ff),
      .push_value (a_val_ff),
      .count      (count_ff),
      .t0         (t0_ff),
      .t1         (t1_ff),
      .t2         (t2_ff),
      .b3         (b3),
      .b4         (b4),
      .count_n    (count_in),
      .t0_n       (t0_in),
      .t1_n       (t1_in),
      .t2_n       (t2_in),
      .popped     (popped),
      .ctl        (ctl),
      .spill_addr (spill_addr),
      .rd3_addr   (rd3_addr),
      .rd4_addr   (rd4_addr)
   );

   // The spill memory holds every entry below the three cached ones. Its read
   // ports always fetch the two entries below the cache for the next depth.
   fdsu_spill_ram #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_spill_ram (
      .clock   (clock),
      .we      (ctl.spill_we),
      .waddr   (spill_addr),
      .wdata   (t2_ff),
      .raddr_a (rd3_addr),
      .raddr_b (rd4_addr),
      .rdata_a (b3),
      .rdata_b (b4)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_cmd_ff <= req_command;
         a_val_ff <= VALUE_WIDTH'(req_push_value);
      end
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      if (fire) begin
         rsp_popped_ff <= popped;
         rsp_err_ff    <= ctl.error_code;
         rsp_depth_ff  <= DEPTH_OUT_W'(count_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = PORT_VAL_W'(rsp_popped_ff);
   assign rsp_error_code   = rsp_err_ff;
   assign rsp_depth_after  = rsp_depth_ff;

endmodule

// ----- design/fdsu_checker.sv -----
// Port-level checker for the Forth data stack unit, bound to the top level.
// Depends on fdsu_pkg and forth_data_stack_unit_top.
module fdsu_checker #(
   parameter int STACK_DEPTH = 64
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [fdsu_pkg::PORT_VAL_W-1:0]     rsp_popped_value,
   input logic [fdsu_pkg::ERR_W-1:0]          rsp_error_code,
   input logic [fdsu_pkg::DEPTH_OUT_W-1:0]    rsp_depth_after
);
   import fdsu_pkg::*;

   // Depth reported by the last delivered response.
   logic [DEPTH_OUT_W-1:0] prev_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_depth_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         prev_depth_ff <= rsp_depth_after;
      end
   end

   // A failed command leaves the depth as it was.
   a_error_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_OK) |-> rsp_depth_after == prev_depth_ff)
      else $error("failed command changed the stack depth");

   // A nonzero popped value only comes from a successful pop, which lowers the depth by one.
   a_pop_lowers_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_popped_value != '0) |->
         (rsp_error_code == ERR_OK) &&
         (DEPTH_OUT_W'(rsp_depth_after + DEPTH_OUT_W'(1)) == prev_depth_ff))
      else $error("popped value without a successful pop");

   // A full error is reported only when the stack holds STACK_DEPTH entries.
   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == ERR_FULL) |->
         prev_depth_ff == DEPTH_OUT_W'(STACK_DEPTH))
      else $error("full error below capacity");

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_value) &&
         $stable(rsp_error_code) && $stable(rsp_depth_after))
      else $error("stalled response changed");

endmodule

bind forth_data_stack_unit_top fdsu_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_fdsu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_popped_value (rsp_popped_value),
   .rsp_error_code   (rsp_error_code),
   .rsp_depth_after  (rsp_depth_after)
);

// ----- sim/forth_stack_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the Forth data stack unit: tracks the stack, predicts each response
// and compares it with what the unit returns. Depends on fdsu_pkg.
module forth_stack_checker #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_WIDTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [fdsu_pkg::CMD_W-1:0]          req_command,
   input  logic [fdsu_pkg::PORT_VAL_W-1:0]     req_push_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [fdsu_pkg::PORT_VAL_W-1:0]     rsp_popped_value,
   input  logic [fdsu_pkg::ERR_W-1:0]          rsp_error_code,
   input  logic [fdsu_pkg::DEPTH_OUT_W-1:0]    rsp_depth_after,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  full_hits,
   output int                                  empty_hits,
   output int                                  underflow_hits
);
   import fdsu_pkg::*;

   typedef struct packed {
      logic [PORT_VAL_W-1:0]  popped_value;
      logic [ERR_W-1:0]       error_code;
      logic [DEPTH_OUT_W-1:0] depth_after;
   } stack_result_type;

   // The counters and the tracked depth start at zero as plain ints.
   logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
   int unsigned            stack_count;
   stack_result_type       awaited_results [$];

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   // Applies one command to the tracked stack and returns the response it must produce.
   task automatic apply_stack_op(input logic [CMD_W-1:0] cmd,
                                 input logic [PORT_VAL_W-1:0] value,
                                 output stack_result_type res);
      int unsigned            n;
      logic [ERR_W-1:0]       err;
      logic [VALUE_WIDTH-1:0] a, b, c;
      n   = stack_count;
      err = ERR_OK;
      res = '0;
      case (cmd)
         CMD_PUSH: begin
            if (n >= STACK_DEPTH) err = ERR_FULL;
            else begin
               stack_mem[n] = value[VALUE_WIDTH-1:0];
               n++;
            end
         end
         CMD_POP: begin
            if (n == 0) err = ERR_EMPTY;
            else begin
               res.popped_value = PORT_VAL_W'(stack_mem[n-1]);
               n--;
            end
         end
         CMD_DUP: begin
            if (n == 0) err = ERR_EMPTY;
            else if (n >= STACK_DEPTH) err = ERR_FULL;
            else begin
               stack_mem[n] = stack_mem[n-1];
               n++;
            end
         end
         CMD_SWAP: begin
            if (n < 2) err = ERR_UNDER;
            else begin
               a = stack_mem[n-2];
               stack_mem[n-2] = stack_mem[n-1];
               stack_mem[n-1] = a;
            end
         end
         CMD_ROT: begin
            // ( a b c -- b c a )
            if (n < 3) err = ERR_UNDER;
            else begin
               a = stack_mem[n-3];
               b = stack_mem[n-2];
               c = stack_mem[n-1];
               stack_mem[n-3] = b;
               stack_mem[n-2] = c;
               stack_mem[n-1] = a;
            end
         end
         CMD_OVER: begin
            // Underflow is checked before a full stack.
            if (n < 2) err = ERR_UNDER;
            else if (n >= STACK_DEPTH) err = ERR_FULL;
            else begin
               stack_mem[n] = stack_mem[n-2];
               n++;
            end
         end
         CMD_DROP: begin
            if (n == 0) err = ERR_EMPTY;
            else n--;
         end
         CMD_DROP2: begin
            if (n < 2) err = ERR_UNDER;
            else n -= 2;
         end
         CMD_MINUS_ROT: begin
            // ( a b c -- c a b )
            if (n < 3) err = ERR_UNDER;
            else begin
               a = stack_mem[n-3];
               b = stack_mem[n-2];
               c = stack_mem[n-1];
               stack_mem[n-3] = c;
               stack_mem[n-2] = a;
               stack_mem[n-1] = b;
            end
         end
         default: ;
      endcase
      stack_count     = n;
      res.error_code  = err;
      res.depth_after = DEPTH_OUT_W'(n);
   endtask

   always @(posedge clock) begin
      stack_result_type want;
      stack_result_type fresh;
      if (reset) begin
         stack_count = 0;
         awaited_results.delete();
      end else begin
         // Responses are handled before requests so a response can never match
         // a request accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               flag_mismatch("response with nothing outstanding, depth",
                             64'(rsp_depth_after), '0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_popped_value !== want.popped_value)
                  flag_mismatch("popped_value", 64'(rsp_popped_value),
                                64'(want.popped_value));
               if (rsp_error_code !== want.error_code)
                  flag_mismatch("error_code", 64'(rsp_error_code), 64'(want.error_code));
               if (rsp_depth_after !== want.depth_after)
                  flag_mismatch("depth_after", 64'(rsp_depth_after),
                                64'(want.depth_after));
            end
         end
         if (req_valid && req_ready) begin
            apply_stack_op(req_command, req_push_value, fresh);
            awaited_results.push_back(fresh);
            case (fresh.error_code)
               ERR_FULL:  full_hits++;
               ERR_EMPTY: empty_hits++;
               ERR_UNDER: underflow_hits++;
               default: ;
            endcase
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

// ----- sim/tb_forth_data_stack_unit_top.sv -----
`timescale 1ns / 100ps
// Top of the Forth data stack unit testbench: clock, reset, request stimulus and verdict.
// Depends on fdsu_pkg, forth_data_stack_unit_top and forth_stack_checker.
module tb_forth_data_stack_unit_top;
   import fdsu_pkg::*;

   localparam int STACK_DEPTH     = 64;
   localparam int VALUE_WIDTH     = 64;
   localparam int RANDOM_REQUESTS = 950;
   // Length of one phase of the random part; phases rotate grow, mixed, shrink.
   localparam int PHASE_LEN       = 110;
   localparam int CYCLE_LIMIT     = 200000;
   // Percentage of cycles in which each side holds off.
   localparam int IDLE_PCT        = 22;

   typedef enum logic [1:0] {GROW_PHASE, MIXED_PHASE, SHRINK_PHASE} phase_type;

   bit                      clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [CMD_W-1:0]        req_command;
   logic [PORT_VAL_W-1:0]   req_push_value;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [PORT_VAL_W-1:0]   rsp_popped_value;
   logic [ERR_W-1:0]        rsp_error_code;
   logic [DEPTH_OUT_W-1:0]  rsp_depth_after;

   int   fail_count;
   int   pending_count;
   int   full_hits;
   int   empty_hits;
   int   underflow_hits;
   int   requests_sent;
   int   cycle_count;
   // High while neither side may idle, so the unit also runs at full rate.
   logic calm;
   // Registered copy of the request handshake, read back at the falling edge.
   logic req_taken = 1'b0;

   forth_data_stack_unit_top #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_popped_value(rsp_popped_value),
      .rsp_error_code  (rsp_error_code),
      .rsp_depth_after (rsp_depth_after)
   );

   forth_stack_checker #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) stack_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_popped_value(rsp_popped_value),
      .rsp_error_code  (rsp_error_code),
      .rsp_depth_after (rsp_depth_after),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .full_hits       (full_hits),
      .empty_hits      (empty_hits),
      .underflow_hits  (underflow_hits)
   );

   // Free-running clock with an 8 ns period.
   initial begin
      forever #4 clock = ~clock;
   end

   // The response side stalls at random except inside the calm window. It changes
   // only at the falling edge, so the unit sees a stable ready at each rising edge.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // The handshake is captured at the rising edge and read by the stimulus at the
   // next falling edge, which keeps the stimulus clear of any race with the unit.
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   // Watchdog: a hung handshake or a lost response ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Push values lean toward the extremes: zero, all ones, a single set bit and a
   // single clear bit, with fully random words for the rest.
   function automatic logic [PORT_VAL_W-1:0] pick_push_value();
      logic [PORT_VAL_W-1:0] one_hot;
      one_hot = '0;
      one_hot[$urandom_range(PORT_VAL_W - 1)] = 1'b1;
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return one_hot;
         3:       return ~one_hot;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // The phase steers the depth: grow phases drive the stack into the full case,
   // shrink phases into the empty and underflow cases, and mixed phases wander
   // around the middle. A few requests carry the unused command codes.
   function automatic logic [CMD_W-1:0] pick_command(input phase_type phase);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3)
         return CMD_W'($urandom_range(CMD_MINUS_ROT + 1, (1 << CMD_W) - 1));
      case (phase)
         GROW_PHASE: begin
            if (roll < 60) return CMD_PUSH;
            if (roll < 75) return CMD_DUP;
            if (roll < 88) return CMD_OVER;
         end
         SHRINK_PHASE: begin
            if (roll < 35) return CMD_POP;
            if (roll < 55) return CMD_DROP;
            if (roll < 70) return CMD_DROP2;
         end
         default: ;
      endcase
      return CMD_W'($urandom_range(CMD_PUSH, CMD_MINUS_ROT));
   endfunction

   // Presents one request, with a random hold-off first, and returns at the
   // falling edge after the unit took it. Valid is left high on return, so a
   // request that follows at once simply replaces the payload.
   task automatic issue_request(input logic [CMD_W-1:0] cmd,
                                input logic [PORT_VAL_W-1:0] value);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_push_value <= value;
      do @(negedge clock); while (!req_taken);
      requests_sent++;
   endtask

   initial begin
      int unsigned step;
      phase_type   phase;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_PUSH;
      req_push_value = '0;
      calm           = 1'b0;
      requests_sent  = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Every command but push is tried on an empty stack first, so each
      // empty and underflow case is seen before any data is stored.
      issue_request(CMD_POP, pick_push_value());
      issue_request(CMD_DROP, pick_push_value());
      issue_request(CMD_DUP, pick_push_value());
      issue_request(CMD_SWAP, pick_push_value());
      issue_request(CMD_DROP2, pick_push_value());
      issue_request(CMD_ROT, pick_push_value());
      issue_request(CMD_MINUS_ROT, pick_push_value());
      issue_request(CMD_OVER, pick_push_value());
      // With one entry the two-entry commands still underflow.
      issue_request(CMD_PUSH, '0);
      issue_request(CMD_OVER, pick_push_value());
      issue_request(CMD_SWAP, pick_push_value());
      issue_request(CMD_DROP2, pick_push_value());
      // With two entries the three-entry rotations still underflow.
      issue_request(CMD_PUSH, '1);
      issue_request(CMD_ROT, pick_push_value());
      issue_request(CMD_MINUS_ROT, pick_push_value());
      // Alternating bit patterns make any mix-up between entries visible.
      issue_request(CMD_PUSH, {(PORT_VAL_W / 2){2'b01}});
      issue_request(CMD_PUSH, {(PORT_VAL_W / 2){2'b10}});
      issue_request(CMD_ROT, pick_push_value());
      issue_request(CMD_MINUS_ROT, pick_push_value());
      issue_request(CMD_SWAP, pick_push_value());
      issue_request(CMD_OVER, pick_push_value());
      issue_request(CMD_DUP, pick_push_value());
      // Unused codes at both ends of their range must leave the stack alone.
      issue_request(CMD_W'(CMD_MINUS_ROT + 1), pick_push_value());
      issue_request(CMD_W'((1 << CMD_W) - 1), pick_push_value());
      issue_request(CMD_POP, pick_push_value());
      issue_request(CMD_DROP2, pick_push_value());
      issue_request(CMD_DROP, pick_push_value());
      issue_request(CMD_POP, pick_push_value());

      // Random part. A window in the middle runs without any idling on either side.
      for (step = 0; step < RANDOM_REQUESTS; step++) begin
         calm  = (step >= 400 && step < 550);
         phase = phase_type'((step / PHASE_LEN) % 3);
         issue_request(pick_command(phase), pick_push_value());
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Wait for every response, then give the pipeline time to show any extra one.
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Sent %0d stack requests over %0d cycles.", requests_sent, cycle_count);
      $display("Predicted errors: %0d full, %0d empty, %0d underflow; %0d mismatches.",
               full_hits, empty_hits, underflow_hits, fail_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
